/* rtl/drive_pi_speed_controller_defines.svh */
// Assertion macros shared by the speed controller's checker.
`ifndef DRIVE_PI_SPEED_CONTROLLER_DEFINES_SVH
`define DRIVE_PI_SPEED_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge of clk outside reset.
`define PISC_ASSERT_IMP(label, trig, resp) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (resp)) \
        else $error("pisc_checker: assertion failed");

// Next-cycle implication, sampled on the rising edge of clk outside reset.
`define PISC_ASSERT_NEXT(label, trig, resp) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (resp)) \
        else $error("pisc_checker: assertion failed");

`endif

/* rtl/pisc_pkg.sv */
// Types, widths and constants shared by the PI speed controller.
package pisc_pkg;

    localparam int COUNT_W            = 10;
    localparam int COUNT_BITS_DEFAULT = 10;
    localparam int GAIN_W             = 16;
    localparam int PULSE_W            = 12;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 16;
    localparam int INTEG_W            = 32;
    localparam int PROD_W             = INTEG_W + GAIN_W + 1;
    localparam int SUM_W              = PROD_W;
    localparam int FRAC_SHIFT         = 18;
    localparam int QUOT_W             = SUM_W - FRAC_SHIFT;
    localparam int RAW_W              = QUOT_W + 2;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
    localparam logic [SUM_W-1:0] ROUND_ADD = SUM_W'((64'd1 << FRAC_SHIFT) - 64'd1);

    localparam logic [PULSE_W-1:0] PENDING_RESET = 12'd1500;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_COUNT   = 3'd0,
        REG_PROP_GAIN      = 3'd1,
        REG_INTEG_GAIN     = 3'd2,
        REG_FWD_MIN_PULSE  = 3'd3,
        REG_FWD_MAX_PULSE  = 3'd4,
        REG_REV_SLOW_PULSE = 3'd5,
        REG_REV_FAST_PULSE = 3'd6,
        REG_NEUTRAL_PULSE  = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic [COUNT_W-1:0] left_count;
        logic [COUNT_W-1:0] right_count;
        logic               reverse_mode;
        logic               stop_request;
        logic               clear_integral;
        logic               enabled;
    } tick_t;

    typedef struct packed {
        logic [PULSE_W-1:0] applied_pulse;
        logic [PULSE_W-1:0] next_pulse;
        logic               clamped;
    } pulse_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  target_count;
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [PULSE_W-1:0] fwd_min_pulse;
        logic [PULSE_W-1:0] fwd_max_pulse;
        logic [PULSE_W-1:0] rev_slow_pulse;
        logic [PULSE_W-1:0] rev_fast_pulse;
        logic [PULSE_W-1:0] neutral_pulse;
    } cfg_t;

    typedef struct packed {
        logic reverse_mode;
        logic stop_request;
        logic enabled;
    } ctrl_t;

    localparam cfg_t CFG_RESET = '{
        target_count:   16'd784,
        prop_gain:      16'd1280,
        integ_gain:     16'd64,
        fwd_min_pulse:  12'd1555,
        fwd_max_pulse:  12'd1590,
        rev_slow_pulse: 12'd1430,
        rev_fast_pulse: 12'd1390,
        neutral_pulse:  12'd1500
    };

endpackage

/* rtl/pisc_integ.sv */
// Speed error and saturating error integral stage.
module pisc_integ #(
    parameter int USED_BITS = 10,
    parameter int ERR_W     = 19
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load,
    input  pisc_pkg::tick_t                       tick,
    input  pisc_pkg::cfg_t                        cfg,
    output logic signed [ERR_W-1:0]               err,
    output logic signed [pisc_pkg::INTEG_W-1:0]   integral,
    output pisc_pkg::ctrl_t                       ctrl
);
    import pisc_pkg::*;

    logic [USED_BITS:0]          count_sum;
    logic signed [ERR_W-1:0]     err_next;
    logic signed [INTEG_W-1:0]   integ_base;
    logic signed [INTEG_W:0]     acc_wide;
    logic signed [INTEG_W-1:0]   integ_next;
    logic signed [ERR_W-1:0]     err_reg;
    logic signed [INTEG_W-1:0]   integ_reg;
    ctrl_t                       ctrl_reg;

    always_comb
    begin
        count_sum  = {1'b0, tick.left_count[USED_BITS-1:0]}
                   + {1'b0, tick.right_count[USED_BITS-1:0]};
        err_next   = $signed(ERR_W'({1'b0, cfg.target_count}))
                   - $signed(ERR_W'({count_sum, 7'b0}));
        integ_base = tick.clear_integral ? '0 : integ_reg;
        acc_wide   = {integ_base[INTEG_W-1], integ_base}
                   + {{(INTEG_W+1-ERR_W){err_next[ERR_W-1]}}, err_next};
        if (acc_wide[INTEG_W] != acc_wide[INTEG_W-1])
        begin
            integ_next = acc_wide[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end
        else
        begin
            integ_next = acc_wide[INTEG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (load && tick.enabled)
        begin
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg  <= err_next;
            ctrl_reg <= '{reverse_mode: tick.reverse_mode,
                          stop_request: tick.stop_request,
                          enabled:      tick.enabled};
        end
    end

    assign err      = err_reg;
    assign integral = integ_reg;
    assign ctrl     = ctrl_reg;

endmodule

/* rtl/pisc_prod.sv */
// Gain products, PI sum and truncating scale-down stages.
module pisc_prod #(
    parameter int ERR_W = 19
) (
    input  logic                                 clk,
    input  logic                                 load_mul,
    input  logic                                 load_quot,
    input  logic signed [ERR_W-1:0]              err,
    input  logic signed [pisc_pkg::INTEG_W-1:0]  integral,
    input  pisc_pkg::ctrl_t                      ctrl_in,
    input  pisc_pkg::cfg_t                       cfg,
    output logic signed [pisc_pkg::QUOT_W-1:0]   quot,
    output pisc_pkg::ctrl_t                      ctrl_out
);
    import pisc_pkg::*;

    localparam int PROP_W = ERR_W + GAIN_W + 1;

    logic signed [PROP_W-1:0]  prop_prod_reg;
    logic signed [PROD_W-1:0]  integ_prod_reg;
    ctrl_t                     ctrl_mul_reg;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   rounded;
    logic signed [QUOT_W-1:0]  quot_reg;
    ctrl_t                     ctrl_quot_reg;

    always_ff @(posedge clk)
    begin
        if (load_mul)
        begin
            prop_prod_reg  <= err * $signed({1'b0, cfg.prop_gain});
            integ_prod_reg <= integral * $signed({1'b0, cfg.integ_gain});
            ctrl_mul_reg   <= ctrl_in;
        end
    end

    // Division by two to the eighteenth, truncated towards zero.
    always_comb
    begin
        sum     = {{(SUM_W-PROP_W-2){prop_prod_reg[PROP_W-1]}}, prop_prod_reg, 2'b00}
                + integ_prod_reg;
        rounded = sum + (sum[SUM_W-1] ? ROUND_ADD : '0);
    end

    always_ff @(posedge clk)
    begin
        if (load_quot)
        begin
            quot_reg      <= rounded[SUM_W-1:FRAC_SHIFT];
            ctrl_quot_reg <= ctrl_mul_reg;
        end
    end

    assign quot     = quot_reg;
    assign ctrl_out = ctrl_quot_reg;

endmodule

/* rtl/pisc_clamp.sv */
// Pulse formation, range clamp, pending pulse and result register.
module pisc_clamp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic signed [pisc_pkg::QUOT_W-1:0]  quot,
    input  pisc_pkg::ctrl_t                     ctrl,
    input  pisc_pkg::cfg_t                      cfg,
    output pisc_pkg::pulse_t                    result
);
    import pisc_pkg::*;

    logic [PULSE_W-1:0]        base;
    logic [PULSE_W-1:0]        hi;
    logic [PULSE_W-1:0]        lo;
    logic signed [RAW_W-1:0]   quot_ext;
    logic signed [RAW_W-1:0]   base_ext;
    logic signed [RAW_W-1:0]   hi_ext;
    logic signed [RAW_W-1:0]   lo_ext;
    logic signed [RAW_W-1:0]   raw;
    logic                      over;
    logic                      under;
    logic [PULSE_W-1:0]        pulse_next;
    logic                      clamp_next;
    logic [PULSE_W-1:0]        pending_reg;
    pulse_t                    result_reg;

    always_comb
    begin
        base     = ctrl.reverse_mode ? cfg.rev_slow_pulse : cfg.fwd_min_pulse;
        hi       = ctrl.reverse_mode ? cfg.rev_slow_pulse : cfg.fwd_max_pulse;
        lo       = ctrl.reverse_mode ? cfg.rev_fast_pulse : cfg.fwd_min_pulse;
        quot_ext = {{(RAW_W-QUOT_W){quot[QUOT_W-1]}}, quot};
        base_ext = {{(RAW_W-PULSE_W){1'b0}}, base};
        hi_ext   = {{(RAW_W-PULSE_W){1'b0}}, hi};
        lo_ext   = {{(RAW_W-PULSE_W){1'b0}}, lo};
        raw      = ctrl.reverse_mode ? base_ext - quot_ext : base_ext + quot_ext;
        over     = raw > hi_ext;
        under    = raw < lo_ext;
        if (ctrl.stop_request)
        begin
            pulse_next = cfg.neutral_pulse;
            clamp_next = 1'b0;
        end
        else
        begin
            // The upper bound wins when the limits are inverted.
            pulse_next = over ? hi : (under ? lo : raw[PULSE_W-1:0]);
            clamp_next = over || under;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= PENDING_RESET;
        end
        else if (load && ctrl.enabled)
        begin
            pending_reg <= pulse_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.applied_pulse <= pending_reg;
            result_reg.next_pulse    <= ctrl.enabled ? pulse_next : pending_reg;
            result_reg.clamped       <= ctrl.enabled && clamp_next;
        end
    end

    assign result = result_reg;

endmodule

/* rtl/drive_pi_speed_controller.sv */
// Top level of the drive-wheel PI speed controller with output clamp.
//
// Each beat on the tick channel carries the two encoder counts of one control
// tick and the mode flags; each beat on the pulse channel carries the pulse
// width applied on this tick, the width computed for the next tick and the
// clamp flag. Every accepted tick gives exactly one pulse beat, in order.
// The work runs through five register stages: input, error and integral,
// gain products, scaled PI sum, and clamp with result register. A result is
// shown after its tick passes the error, product, sum and result registers;
// one tick can be accepted in every cycle while tick_stall is low; the integral
// loop closes within the error stage. When pulse_stall is held, the result
// register keeps its beat and the earlier stages go on filling; tick_stall
// rises only when all five stages hold a beat. The configuration channel is
// always ready and a write takes effect on the following cycle; the user must
// write it only while the block is idle, which the block does not enforce.
// Reset loads the register defaults, clears the integral, sets the pending pulse to 1500 and empties the pipeline.
module drive_pi_speed_controller #(
    parameter int COUNT_BITS = pisc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick_valid,
    output logic                                tick_stall,
    input  pisc_pkg::tick_t                     tick,
    output logic                                pulse_valid,
    input  logic                                pulse_stall,
    output pisc_pkg::pulse_t                    pulse,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pisc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pisc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pisc_pkg::*;

    localparam int USED_BITS  = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;
    localparam int ERR_W      = (USED_BITS + 9 > 17) ? USED_BITS + 9 : 17;
    localparam int NUM_STAGES = 5;

    logic [NUM_STAGES-1:0]     valid_reg;
    logic [NUM_STAGES-1:0]     valid_next;
    logic [NUM_STAGES-1:0]     ready;
    logic [NUM_STAGES-1:0]     load;
    tick_t                     tick_reg;
    cfg_t                      cfg_reg;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integral;
    ctrl_t                     ctrl_integ;
    logic signed [QUOT_W-1:0]  quot;
    ctrl_t                     ctrl_quot;

    // A stage takes a new beat when it is empty or its beat moves on.
    always_comb
    begin
        ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !pulse_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        load[0]       = tick_valid && ready[0];
        valid_next[0] = ready[0] ? tick_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            load[k]       = valid_reg[k-1] && ready[k];
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            cfg_reg   <= CFG_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_valid)
            begin
                case (cfg_reg_e'(cfg_index))
                    REG_TARGET_COUNT:   cfg_reg.target_count   <= cfg_data;
                    REG_PROP_GAIN:      cfg_reg.prop_gain      <= cfg_data;
                    REG_INTEG_GAIN:     cfg_reg.integ_gain     <= cfg_data;
                    REG_FWD_MIN_PULSE:  cfg_reg.fwd_min_pulse  <= cfg_data[PULSE_W-1:0];
                    REG_FWD_MAX_PULSE:  cfg_reg.fwd_max_pulse  <= cfg_data[PULSE_W-1:0];
                    REG_REV_SLOW_PULSE: cfg_reg.rev_slow_pulse <= cfg_data[PULSE_W-1:0];
                    REG_REV_FAST_PULSE: cfg_reg.rev_fast_pulse <= cfg_data[PULSE_W-1:0];
                    REG_NEUTRAL_PULSE:  cfg_reg.neutral_pulse  <= cfg_data[PULSE_W-1:0];
                    default:            cfg_reg                <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            tick_reg <= tick;
        end
    end

    pisc_integ #(
        .USED_BITS (USED_BITS),
        .ERR_W     (ERR_W)
    ) u_integ (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load[1]),
        .tick     (tick_reg),
        .cfg      (cfg_reg),
        .err      (err),
        .integral (integral),
        .ctrl     (ctrl_integ)
    );

    pisc_prod #(
        .ERR_W (ERR_W)
    ) u_prod (
        .clk       (clk),
        .load_mul  (load[2]),
        .load_quot (load[3]),
        .err       (err),
        .integral  (integral),
        .ctrl_in   (ctrl_integ),
        .cfg       (cfg_reg),
        .quot      (quot),
        .ctrl_out  (ctrl_quot)
    );

    pisc_clamp u_clamp (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load[4]),
        .quot   (quot),
        .ctrl   (ctrl_quot),
        .cfg    (cfg_reg),
        .result (pulse)
    );

    assign tick_stall  = !ready[0];
    assign pulse_valid = valid_reg[NUM_STAGES-1];
    assign cfg_ready   = 1'b1;

endmodule

/* rtl/pisc_checker.sv */
// Port-level checker for the speed controller, with its bind.
`include "drive_pi_speed_controller_defines.svh"

module pisc_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick_stall,
    input  logic              pulse_valid,
    input  logic              pulse_stall,
    input  pisc_pkg::pulse_t  pulse
);
    import pisc_pkg::*;

    logic [PULSE_W-1:0] prev_next_reg;
    logic               have_prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_next_reg <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (pulse_valid && !pulse_stall)
        begin
            prev_next_reg <= pulse.next_pulse;
            have_prev_reg <= 1'b1;
        end
    end

    // Each beat applies the width that the beat before it computed.
    `PISC_ASSERT_IMP(a_applied_follows, pulse_valid && have_prev_reg, pulse.applied_pulse == prev_next_reg)
    `PISC_ASSERT_IMP(a_first_applied, pulse_valid && !have_prev_reg, pulse.applied_pulse == PENDING_RESET)
    `PISC_ASSERT_IMP(a_no_false_stall, !pulse_valid, !tick_stall)
    `PISC_ASSERT_NEXT(a_result_holds, pulse_valid && pulse_stall, pulse_valid && $stable(pulse))

endmodule

bind drive_pi_speed_controller pisc_checker u_pisc_checker (.*);
